// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define VMSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vmsd assertion failed");
// Checked in and out of reset.
`define VMSD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("vmsd reset assertion failed");
`else
`define VMSD_ASSERT(lbl, prop)
`define VMSD_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/vmsd_pkg.sv =====
// Types, constants and codes for the voxel mean and std dev block.
`default_nettype none
package vmsd_pkg;

  localparam int SUM_W      = 24;
  localparam int SQ_W       = 48;
  localparam int WT_W       = 16;
  localparam int MINW_W     = 8;
  localparam int FRAC_W     = 8;
  localparam int DIVD_W     = 56;          // dividend/quotient width of every divider row
  localparam int DIV_STEPS  = DIVD_W;      // one quotient bit per cell
  localparam int ROOT_W     = DIVD_W / 2;
  localparam int SQRT_STEPS = ROOT_W;      // one root bit per cell
  localparam int SREM_W     = ROOT_W + 2;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [WT_W-1:0]  WT_ONE  = WT_W'(1) << FRAC_W;

  typedef enum logic [2:0] {
    REG_SD_ENABLE     = 3'd0,
    REG_INCLUDE_MODE  = 3'd1,
    REG_DIVISOR_MODE  = 3'd2,
    REG_MIN_WEIGHT    = 3'd3,
    REG_GLOBAL_WEIGHT = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    INC_ALL  = 2'd0,
    INC_MINW = 2'd1,
    INC_FULL = 2'd2,
    INC_RSVD = 2'd3
  } include_e;

  typedef enum logic [1:0] {
    DIVM_NONE   = 2'd0,
    DIVM_GLOBAL = 2'd1,
    DIVM_LOCAL  = 2'd2,
    DIVM_RSVD   = 2'd3
  } divisor_e;

  // What happens to the sum once its quotient is known
  typedef enum logic [1:0] {
    KIND_KEEP  = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_FAULT = 2'd2,
    KIND_DIV   = 2'd3
  } kind_e;

  typedef struct packed {
    logic             sd_enable;
    include_e         include_mode;
    divisor_e         divisor_mode;
    logic [MINW_W-1:0] min_weight;
    logic [WT_W-1:0]  global_weight;
  } cfg_t;

  typedef struct packed {
    logic [WT_W-1:0]   rem;
    logic [DIVD_W-1:0] dq;   // dividend bits out the top, quotient bits in the bottom
    logic [WT_W-1:0]   den;
  } div_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [DIVD_W-1:0] rad;
  } sqrt_t;

  // Side data riding along the first divider rows
  typedef struct packed {
    logic             valid;
    logic             last;
    kind_e            kind;
    logic             sd_en;
    logic             sd_zero;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [WT_W-1:0]  wt;
  } sb1_t;

  // Side data riding along the variance divider and root rows
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             sd_en;
    logic             sd_zero;
    logic             fault;
    logic [SUM_W-1:0] scaled;
    logic [SQ_W-1:0]  sq;
  } sb2_t;

endpackage
`default_nettype wire

// ===== design/vmsd_in_if.sv =====
// Input word channel: valid/ready plus voxel payload.
`default_nettype none
interface vmsd_in_if;
  import vmsd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] pixel_sum;
  logic [SQ_W-1:0]         sum_of_squares;
  logic [WT_W-1:0]         weight_total;
  logic                    last_voxel;

  modport source (output valid, pixel_sum, sum_of_squares, weight_total, last_voxel,
                  input ready);
  modport sink   (input valid, pixel_sum, sum_of_squares, weight_total, last_voxel,
                  output ready);
endinterface
`default_nettype wire

// ===== design/vmsd_out_if.sv =====
// Result word channel: valid/ready plus result payload.
`default_nettype none
interface vmsd_out_if;
  import vmsd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] scaled_value;
  logic [SQ_W-1:0]         std_dev;
  logic                    div_fault;
  logic                    last_out;

  modport source (output valid, scaled_value, std_dev, div_fault, last_out, input ready);
  modport sink   (input valid, scaled_value, std_dev, div_fault, last_out, output ready);
endinterface
`default_nettype wire

// ===== design/voxel_mean_and_std_dev.sv =====
// Voxel mean and standard deviation. Takes one voxel word per cycle (sum,
// sum of squares, weight) and returns one result word per voxel, in order:
// the sum normalised or masked per include_mode/divisor_mode, saturated to
// Q15.8, and either the sample standard deviation (Q15.8) or the sum of
// squares passed through. Sustained rate is one word per cycle while the
// output is not stalled. The pipe is three rows of 56 restoring-division
// cells (sum quotient and sum^2/n side by side, then the variance
// quotient) and a row of 28 square-root cells, plus input, middle and
// output registers. The whole pipe advances whenever the output register
// is empty or being read, so an output stall holds every stage.
// Configuration goes through an APB port and should be written only
// while no voxel is in flight.
`default_nettype none
`include "assert_macros.svh"
module voxel_mean_and_std_dev (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vmsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [vmsd_pkg::DATA_W-1:0] pwdata,
  output logic [vmsd_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  vmsd_in_if.sink                          in_i,
  vmsd_out_if.source                       out_o
);
  import vmsd_pkg::*;

  localparam int SB2_DEPTH = DIV_STEPS + SQRT_STEPS;

  cfg_t cfg;
  logic adv;   // whole pipe moves one stage

  assign pready = 1'b1;

  vmsd_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg_o (cfg)
  );

  // ---------------- stage 0: decode, magnitude, square ----------------
  logic [SUM_W-1:0] mag_in;
  logic [SQ_W-1:0]  sq_in;
  kind_e            kind_in;
  logic [WT_W-1:0]  den_in;
  logic [WT_W-1:0]  w_in;
  sb1_t             sb1_in;

  assign w_in   = in_i.weight_total;
  assign mag_in = in_i.pixel_sum[SUM_W-1] ? SUM_W'(-in_i.pixel_sum) : in_i.pixel_sum;
  assign sq_in  = mag_in * mag_in;

  always_comb begin
    kind_in = KIND_KEEP;
    den_in  = cfg.global_weight;
    unique case (cfg.include_mode)
      INC_ALL: begin
        unique case (cfg.divisor_mode)
          DIVM_GLOBAL: kind_in = (cfg.global_weight == '0) ? KIND_FAULT : KIND_DIV;
          DIVM_LOCAL: begin
            // zero local weight leaves the sum alone
            den_in  = w_in;
            kind_in = (w_in != '0) ? KIND_DIV : KIND_KEEP;
          end
          default: kind_in = KIND_KEEP;
        endcase
      end
      INC_MINW: begin
        den_in = w_in;
        if (w_in >= {cfg.min_weight, {FRAC_W{1'b0}}}) begin
          kind_in = (w_in == '0) ? KIND_FAULT : KIND_DIV;
        end else begin
          kind_in = KIND_ZERO;
        end
      end
      default: begin
        // fully sampled; the spare code behaves the same
        if (w_in == cfg.global_weight) begin
          kind_in = (cfg.global_weight == '0) ? KIND_FAULT : KIND_DIV;
        end else begin
          kind_in = KIND_ZERO;
        end
      end
    endcase
  end

  always_comb begin
    sb1_in.valid   = in_i.valid;
    sb1_in.last    = in_i.last_voxel;
    sb1_in.kind    = kind_in;
    sb1_in.sd_en   = cfg.sd_enable;
    sb1_in.sd_zero = (w_in <= WT_ONE) || (in_i.sum_of_squares == '0);
    sb1_in.sum     = in_i.pixel_sum;
    sb1_in.sq      = in_i.sum_of_squares;
    sb1_in.wt      = w_in;
  end

  div_t a_s0_q, b_s0_q;
  sb1_t sb1_q [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_s0_q <= '{rem: '0, dq: DIVD_W'({mag_in, {FRAC_W{1'b0}}}), den: den_in};
      b_s0_q <= '{rem: '0, dq: DIVD_W'({sq_in, {FRAC_W{1'b0}}}), den: w_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIV_STEPS; i++) sb1_q[i] <= '0;
    end else if (adv) begin
      sb1_q[0] <= sb1_in;
      for (int i = 1; i <= DIV_STEPS; i++) sb1_q[i] <= sb1_q[i-1];
    end
  end

  // ---------------- rows A (sum / divisor) and B (sum^2*256 / W) ----------------
  div_t row_a [DIV_STEPS+1];
  div_t row_b [DIV_STEPS+1];
  assign row_a[0] = a_s0_q;
  assign row_b[0] = b_s0_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_row_ab
    vmsd_div_cell u_a (.clk_i, .en_i(adv), .d_i(row_a[k]), .q_o(row_a[k+1]));
    vmsd_div_cell u_b (.clk_i, .en_i(adv), .d_i(row_b[k]), .q_o(row_b[k+1]));
  end

  // ---------------- middle stage: saturate, mask, variance numerator ----------------
  sb1_t              sbm;
  logic [DIVD_W-1:0] qa, t;
  logic [SUM_W-1:0]  sat_val, scaled_m;
  logic              fault_m, t_ge;
  logic [SQ_W-1:0]   diff_m;
  sb2_t              sb2_in;

  assign sbm  = sb1_q[DIV_STEPS];
  assign qa   = row_a[DIV_STEPS].dq;
  assign t    = row_b[DIV_STEPS].dq;
  assign t_ge = t >= DIVD_W'(sbm.sq);
  assign diff_m = sbm.sq - t[SQ_W-1:0];

  always_comb begin
    if (qa[DIVD_W-1:SUM_W-1] != '0) begin
      sat_val = sbm.sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_val = sbm.sum[SUM_W-1] ? SUM_W'(-qa[SUM_W-1:0]) : qa[SUM_W-1:0];
    end
    fault_m = 1'b0;
    case (sbm.kind)
      KIND_KEEP:  scaled_m = sbm.sum;
      KIND_ZERO:  scaled_m = '0;
      KIND_FAULT: begin
        scaled_m = '0;
        fault_m  = 1'b1;
      end
      default:    scaled_m = sat_val;
    endcase
  end

  always_comb begin
    sb2_in.valid   = sbm.valid;
    sb2_in.last    = sbm.last;
    sb2_in.sd_en   = sbm.sd_en;
    sb2_in.sd_zero = sbm.sd_zero || t_ge;
    sb2_in.fault   = fault_m;
    sb2_in.scaled  = scaled_m;
    sb2_in.sq      = sbm.sq;
  end

  div_t c_m_q;
  sb2_t sb2_q [SB2_DEPTH+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_m_q <= '{rem: '0, dq: DIVD_W'({diff_m, {FRAC_W{1'b0}}}), den: sbm.wt - WT_ONE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SB2_DEPTH; i++) sb2_q[i] <= '0;
    end else if (adv) begin
      sb2_q[0] <= sb2_in;
      for (int i = 1; i <= SB2_DEPTH; i++) sb2_q[i] <= sb2_q[i-1];
    end
  end

  // ---------------- row C (variance) then root row ----------------
  div_t  row_c [DIV_STEPS+1];
  sqrt_t row_r [SQRT_STEPS+1];
  assign row_c[0] = c_m_q;
  assign row_r[0] = '{rem: '0, root: '0, rad: row_c[DIV_STEPS].dq};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_row_c
    vmsd_div_cell u_c (.clk_i, .en_i(adv), .d_i(row_c[k]), .q_o(row_c[k+1]));
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_row_r
    vmsd_sqrt_cell u_r (.clk_i, .en_i(adv), .d_i(row_r[k]), .q_o(row_r[k+1]));
  end

  // ---------------- output register ----------------
  sb2_t            sbf;
  logic [SQ_W-1:0] std_f;
  logic            out_valid_q;
  logic [SUM_W-1:0] out_scaled_q;
  logic [SQ_W-1:0]  out_std_q;
  logic             out_fault_q, out_last_q, out_sden_q;

  assign sbf = sb2_q[SB2_DEPTH];
  assign std_f = !sbf.sd_en ? sbf.sq :
                 (sbf.sd_zero ? '0 : SQ_W'(row_r[SQRT_STEPS].root));

  assign adv = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sbf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_scaled_q <= sbf.scaled;
      out_std_q    <= std_f;
      out_fault_q  <= sbf.fault;
      out_last_q   <= sbf.last;
      out_sden_q   <= sbf.sd_en;
    end
  end

  assign in_i.ready         = adv;
  assign out_o.valid        = out_valid_q;
  assign out_o.scaled_value = out_scaled_q;
  assign out_o.std_dev      = out_std_q;
  assign out_o.div_fault    = out_fault_q;
  assign out_o.last_out     = out_last_q;

  // ---------------- checks ----------------
  `VMSD_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_q)
  `VMSD_ASSERT(a_take_enters_pipe, in_i.valid && in_i.ready |=> sb1_q[0].valid)
  `VMSD_ASSERT(a_fault_zero, out_valid_q && out_fault_q |-> out_scaled_q == '0)
  `VMSD_ASSERT(a_root_fits, out_valid_q && out_sden_q |-> out_std_q[SQ_W-1:ROOT_W] == '0)

endmodule
`default_nettype wire

// ===== design/vmsd_cfg.sv =====
// APB configuration registers.
`default_nettype none
module vmsd_cfg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [vmsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [vmsd_pkg::DATA_W-1:0] pwdata,
  output logic [vmsd_pkg::DATA_W-1:0]      prdata,
  output vmsd_pkg::cfg_t             cfg_o
);
  import vmsd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_SD_ENABLE:     cfg_d.sd_enable     = pwdata[0];
        REG_INCLUDE_MODE:  cfg_d.include_mode  = include_e'(pwdata[1:0]);
        REG_DIVISOR_MODE:  cfg_d.divisor_mode  = divisor_e'(pwdata[1:0]);
        REG_MIN_WEIGHT:    cfg_d.min_weight    = pwdata[MINW_W-1:0];
        REG_GLOBAL_WEIGHT: cfg_d.global_weight = pwdata[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SD_ENABLE:     prdata = DATA_W'(cfg_q.sd_enable);
      REG_INCLUDE_MODE:  prdata = DATA_W'(cfg_q.include_mode);
      REG_DIVISOR_MODE:  prdata = DATA_W'(cfg_q.divisor_mode);
      REG_MIN_WEIGHT:    prdata = DATA_W'(cfg_q.min_weight);
      REG_GLOBAL_WEIGHT: prdata = DATA_W'(cfg_q.global_weight);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sd_enable: 1'b0, include_mode: INC_ALL, divisor_mode: DIVM_NONE,
                 min_weight: '0, global_weight: WT_ONE};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ===== design/vmsd_div_cell.sv =====
// One restoring-division cell: one quotient bit per stage.
`default_nettype none
module vmsd_div_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  vmsd_pkg::div_t     d_i,
  output vmsd_pkg::div_t     q_o
);
  import vmsd_pkg::*;

  div_t            data_q, data_d;
  logic [WT_W:0]   trial;
  logic [WT_W:0]   diff;
  logic            ge;

  always_comb begin
    trial  = {d_i.rem, d_i.dq[DIVD_W-1]};
    diff   = trial - {1'b0, d_i.den};
    ge     = trial >= {1'b0, d_i.den};
    data_d.den = d_i.den;
    data_d.rem = ge ? diff[WT_W-1:0] : trial[WT_W-1:0];
    data_d.dq  = {d_i.dq[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;
endmodule
`default_nettype wire

// ===== design/vmsd_sqrt_cell.sv =====
// One digit-by-digit square root cell: one root bit per stage.
`default_nettype none
module vmsd_sqrt_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  vmsd_pkg::sqrt_t    d_i,
  output vmsd_pkg::sqrt_t    q_o
);
  import vmsd_pkg::*;

  sqrt_t             data_q, data_d;
  logic [SREM_W-1:0] part, trial;
  logic              ge;

  always_comb begin
    part  = {d_i.rem[SREM_W-3:0], d_i.rad[DIVD_W-1 -: 2]};
    trial = {d_i.root, 2'b01};
    ge    = part >= trial;
    data_d.rem  = ge ? (part - trial) : part;
    data_d.root = {d_i.root[ROOT_W-2:0], ge};
    data_d.rad  = {d_i.rad[DIVD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;
endmodule
`default_nettype wire
